>>> rtl/mbq_pkg.sv
// Package with the types, codes and constants of the multi-pin button qualifier.
package mbq_pkg;

    localparam int PINS = 32;
    localparam int PIN_AW = (PINS > 1) ? $clog2(PINS) : 1;

    localparam logic [15:0] HOLD_TIME_RST = 16'd1500;
    localparam logic [9:0] ANALOG_TOP_RST = 10'd800;
    localparam logic [9:0] ANALOG_BOTTOM_RST = 10'd200;

    typedef logic [2:0] t_opcode;
    localparam t_opcode OP_EDGE = 3'd0;
    localparam t_opcode OP_FILTERED = 3'd1;
    localparam t_opcode OP_TWO_STATE = 3'd2;
    localparam t_opcode OP_PRESS_HOLD = 3'd3;
    localparam t_opcode OP_ANALOG = 3'd4;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_HOLD_TIME = 2'd0;
    localparam t_cfg_index CFG_ANALOG_TOP = 2'd1;
    localparam t_cfg_index CFG_ANALOG_BOTTOM = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_SET      = 2'd1,
        ST_ACTIVE   = 2'd2,
        ST_RELEASED = 2'd3
    } t_pin_state;

    typedef struct packed {
        t_pin_state  state;
        logic [31:0] press_start;
    } t_pin_entry;

    localparam int ENTRY_W = $bits(t_pin_entry);

    typedef struct packed {
        logic [15:0] hold_time;
        logic [9:0]  analog_top;
        logic [9:0]  analog_bottom;
    } t_cfg;

    typedef struct packed {
        t_opcode     opcode;
        logic [4:0]  pin;
        logic        level;
        logic        active_low;
        logic [9:0]  analog_sample;
        logic [7:0]  value_a;
        logic [7:0]  value_b;
        logic [7:0]  slot;
        logic [31:0] now_ms;
    } t_poll;

    typedef struct packed {
        logic       emitted;
        logic [7:0] out_value;
        logic [7:0] out_slot;
    } t_result;

endpackage

>>> rtl/mbq_poll_if.sv
// Interface of the poll channel: one word is one poll of one pin.
interface mbq_poll_if;
    import mbq_pkg::*;

    logic        valid;
    logic        ready;
    t_opcode     opcode;
    logic [4:0]  pin;
    logic        level;
    logic        active_low;
    logic [9:0]  analog_sample;
    logic [7:0]  value_a;
    logic [7:0]  value_b;
    logic [7:0]  slot;
    logic [31:0] now_ms;

    modport source (
        output valid, opcode, pin, level, active_low, analog_sample,
               value_a, value_b, slot, now_ms,
        input  ready
    );

    modport sink (
        input  valid, opcode, pin, level, active_low, analog_sample,
               value_a, value_b, slot, now_ms,
        output ready
    );
endinterface

>>> rtl/mbq_result_if.sv
// Interface of the result channel: one word per poll.
interface mbq_result_if;
    logic       valid;
    logic       ready;
    logic       emitted;
    logic [7:0] out_value;
    logic [7:0] out_slot;

    modport source (
        output valid, emitted, out_value, out_slot,
        input  ready
    );

    modport sink (
        input  valid, emitted, out_value, out_slot,
        output ready
    );
endinterface

>>> rtl/multi_pin_button_qualifier.sv
// Top level of the multi-pin button qualifier: pin-state memory, pipeline and ports.
//
// The block returns one result word per poll, in order. The state and press
// timestamp of every pin live in one 34-bit by 32-entry RAM: each poll's entry
// is read as the poll is taken and written back by the qualify stage. A poll of
// the same pin that follows directly takes the entry just written through a
// forwarding path, so one poll word is taken per clock for any pin order when not
// stalled. Per-pin valid bits, cleared by reset, make a never-written entry read
// as idle with a zero timestamp, so there is no clearing pass after reset. Results
// wait in an output register; the block stalls only when that register and the
// qualify stage are both full and the result is not taken. The user must write
// the configuration only while idle; the block does not enforce it.
module multi_pin_button_qualifier (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mbq_poll_if.sink              i_poll,
    mbq_result_if.source          o_result,
    input  logic                  i_cfg_we,
    input  mbq_pkg::t_cfg_index   i_cfg_index,
    input  logic [15:0]           i_cfg_data
);
    import mbq_pkg::*;

    t_cfg              r_cfg;
    logic              r_s1_valid;
    t_poll             r_s1;
    logic              r_out_valid;
    t_result           r_out;
    logic [PINS-1:0]   r_pin_valid;
    logic              r_fwd_en;
    logic [PIN_AW-1:0] r_fwd_pin;
    t_pin_entry        r_fwd_entry;

    t_poll             in_poll;
    logic              out_free;
    logic              s1_go;
    logic              fire_in;
    logic              in_range;
    logic [PIN_AW-1:0] s1_idx;
    logic [PIN_AW-1:0] raddr;
    logic              ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    t_pin_entry        cur_entry;
    t_pin_entry        q_entry;
    t_result           q_result;

    assign in_poll.opcode = i_poll.opcode;
    assign in_poll.pin = i_poll.pin;
    assign in_poll.level = i_poll.level;
    assign in_poll.active_low = i_poll.active_low;
    assign in_poll.analog_sample = i_poll.analog_sample;
    assign in_poll.value_a = i_poll.value_a;
    assign in_poll.value_b = i_poll.value_b;
    assign in_poll.slot = i_poll.slot;
    assign in_poll.now_ms = i_poll.now_ms;

    assign out_free = !r_out_valid || o_result.ready;
    assign s1_go = r_s1_valid && out_free;
    assign i_poll.ready = !r_s1_valid || out_free;
    assign fire_in = i_poll.valid && i_poll.ready;

    assign in_range = {1'b0, r_s1.pin} < 6'(PINS);
    assign s1_idx = r_s1.pin[PIN_AW-1:0];
    assign raddr = fire_in ? i_poll.pin[PIN_AW-1:0] : s1_idx;
    assign ram_we = s1_go && in_range;

    mbq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PINS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s1_idx),
        .i_wdata (q_entry),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_fwd_en && r_fwd_pin == s1_idx) begin
            cur_entry = r_fwd_entry;
        end else if (r_pin_valid[s1_idx]) begin
            cur_entry = t_pin_entry'(ram_rdata);
        end else begin
            cur_entry = '{state: ST_IDLE, press_start: 32'd0};
        end
    end

    mbq_qualify u_qualify (
        .i_poll   (r_s1),
        .i_cfg    (r_cfg),
        .i_entry  (cur_entry),
        .o_entry  (q_entry),
        .o_result (q_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{hold_time: HOLD_TIME_RST, analog_top: ANALOG_TOP_RST,
                       analog_bottom: ANALOG_BOTTOM_RST};
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_pin_valid <= '0;
            r_fwd_en <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HOLD_TIME:     r_cfg.hold_time <= i_cfg_data;
                    CFG_ANALOG_TOP:    r_cfg.analog_top <= i_cfg_data[9:0];
                    CFG_ANALOG_BOTTOM: r_cfg.analog_bottom <= i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
            if (i_poll.ready) begin
                r_s1_valid <= i_poll.valid;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (ram_we) begin
                r_pin_valid[s1_idx] <= 1'b1;
            end
            r_fwd_en <= ram_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_in) begin
            r_s1 <= in_poll;
        end
        if (s1_go) begin
            r_out <= in_range ? q_result : '0;
        end
        if (ram_we) begin
            r_fwd_pin <= s1_idx;
            r_fwd_entry <= q_entry;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.emitted = r_out.emitted;
    assign o_result.out_value = r_out.out_value;
    assign o_result.out_slot = r_out.out_slot;
endmodule

>>> rtl/mbq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/mbq_qualify.sv
// Next-state and result logic for one poll, given the current entry of its pin.
module mbq_qualify (
    input  mbq_pkg::t_poll      i_poll,
    input  mbq_pkg::t_cfg       i_cfg,
    input  mbq_pkg::t_pin_entry i_entry,
    output mbq_pkg::t_pin_entry o_entry,
    output mbq_pkg::t_result    o_result
);
    import mbq_pkg::*;

    logic        pressed;
    logic        first;
    logic        second;
    logic [31:0] elapsed;
    logic        hold_over;
    t_pin_state  st;
    logic        emit;
    logic [7:0]  val;

    assign pressed = i_poll.level ^ i_poll.active_low;
    assign first = i_poll.analog_sample >= i_cfg.analog_top;
    assign second = !first && (i_poll.analog_sample <= i_cfg.analog_bottom);
    assign elapsed = i_poll.now_ms - i_entry.press_start;
    assign hold_over = elapsed > {16'd0, i_cfg.hold_time};
    assign st = i_entry.state;

    always_comb begin
        o_entry = i_entry;
        emit = 1'b0;
        val = 8'd0;
        unique case (i_poll.opcode)
            OP_EDGE: begin
                if (pressed && st == ST_IDLE) begin
                    o_entry.state = ST_SET;
                    emit = 1'b1;
                    val = i_poll.value_a;
                end else if (!pressed) begin
                    o_entry.state = ST_IDLE;
                end
            end
            OP_FILTERED: begin
                if (pressed && st == ST_IDLE) begin
                    o_entry.state = ST_SET;
                end else if (pressed && st == ST_SET) begin
                    o_entry.state = ST_ACTIVE;
                    emit = 1'b1;
                    val = i_poll.value_a;
                end else if (!pressed && st == ST_ACTIVE) begin
                    o_entry.state = ST_RELEASED;
                end else if (!pressed && st == ST_RELEASED) begin
                    o_entry.state = ST_IDLE;
                end
            end
            OP_TWO_STATE: begin
                if (pressed && st == ST_IDLE) begin
                    o_entry.state = ST_SET;
                    emit = 1'b1;
                    val = i_poll.value_a;
                end else if (!pressed && st != ST_IDLE) begin
                    o_entry.state = ST_IDLE;
                    emit = 1'b1;
                    val = i_poll.value_b;
                end
            end
            OP_PRESS_HOLD: begin
                if (pressed && st == ST_IDLE) begin
                    o_entry.state = ST_SET;
                    o_entry.press_start = i_poll.now_ms;
                end else if (pressed && st == ST_SET && hold_over) begin
                    o_entry.state = ST_ACTIVE;
                    emit = 1'b1;
                    val = i_poll.value_b;
                end else if (!pressed && st == ST_SET) begin
                    o_entry.state = ST_IDLE;
                    emit = 1'b1;
                    val = i_poll.value_a;
                end else if (!pressed && st == ST_ACTIVE) begin
                    o_entry.state = ST_IDLE;
                end
            end
            OP_ANALOG: begin
                if (!first && !second) begin
                    o_entry.state = ST_IDLE;
                end else if (st == ST_IDLE) begin
                    o_entry.state = ST_SET;
                    emit = 1'b1;
                    val = first ? i_poll.value_a : i_poll.value_b;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.emitted = emit;
    assign o_result.out_value = val;
    assign o_result.out_slot = emit ? i_poll.slot : 8'd0;
endmodule
